// File: hdl/ten_day_temperature_averager_core_macros.svh
// Assertion macros used by the checker file of the temperature averager.
`ifndef TEN_DAY_TEMPERATURE_AVERAGER_CORE_MACROS_SVH
`define TEN_DAY_TEMPERATURE_AVERAGER_CORE_MACROS_SVH

// Check on every clock edge outside reset.
`define TDTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define TDTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/tdta_pkg.sv
// Types and fixed constants of the temperature averager.
package tdta_pkg;

  localparam int unsigned SERIES_W = 2;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned QUO_W    = 16;

  typedef struct packed {
    logic [SERIES_W-1:0]        series;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SERIES_W-1:0]        series_out;
    logic signed [SAMPLE_W-1:0] weighted_mean;
    logic signed [SAMPLE_W-1:0] plain_mean;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_WSTART,
    ST_WWAIT,
    ST_PSTART,
    ST_PWAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/tdta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdta_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tdta_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module tdta_div
  import tdta_pkg::*;
#(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output div_stat_t        stat_o
);

  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [QUO_W-1:0]  qs_q, qs_d;
  logic [DEN_W:0]    cand;
  logic [DEN_W:0]    diff;
  logic              fits;

  // The quotient is known to fit QUO_W bits, so the upper dividend bits
  // already sit below the divisor and seed the remainder.
  assign cand = {rem_q, qs_q[QUO_W-1]};
  assign fits = cand >= {1'b0, den_q};
  assign diff = cand - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    qs_d   = qs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = DEN_W'(num_i >> QUO_W);
      qs_d   = num_i[QUO_W-1:0];
    end else if (busy_q) begin
      rem_d  = fits ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
      qs_d   = {qs_q[QUO_W-2:0], fits};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qs_q  <= qs_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o       = qs_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: hdl/ten_day_temperature_averager_core.sv
// Items are taken one at a time; ready returns as the result is registered.
// The time is set by the history walk (one RAM read per day) and two 16-step divisions.
// An item for a series beyond SERIES_COUNT is taken in and dropped without a result.
// Reset clears fill counts, write pointers and handshake state; history is left as is.
// Results wait in an output register, so a new item may enter while one is held.
module ten_day_temperature_averager_core
  import tdta_pkg::*;
#(
  parameter int unsigned WINDOW       = 10,
  parameter int unsigned SERIES_COUNT = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned SER_W    = (SERIES_COUNT > 1) ? $clog2(SERIES_COUNT) : 1;
  localparam int unsigned SLOT_W   = $clog2(WINDOW);
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned WTOT_MAX = WINDOW * (WINDOW + 1) / 2;
  localparam int unsigned DEN_W    = $clog2(WTOT_MAX + 1);
  localparam int unsigned ACC_W    = SAMPLE_W + 1 + DEN_W;
  localparam int unsigned ADDR_W   = SER_W + SLOT_W;
  localparam int unsigned DEPTH    = 1 << ADDR_W;

  state_e state_q, state_d;

  // Input decode.
  logic [SER_W+1:0] in_ser_ext;
  logic [SER_W-1:0] in_idx;
  logic             in_range;
  logic             in_acc;

  // Per-series ring pointer and fill count.
  logic [SLOT_W-1:0] head_q [SERIES_COUNT];
  logic [CNT_W-1:0]  fill_q [SERIES_COUNT];
  logic [SLOT_W-1:0] head_cur, head_new;
  logic [CNT_W-1:0]  fill_cur, fill_new;

  // Walk and accumulate.
  logic [SER_W-1:0]           ser_q;
  logic [CNT_W-1:0]           n_q;
  logic [CNT_W-1:0]           rd_cnt_q;
  logic [CNT_W-1:0]           w_q;
  logic                       pend_q;
  logic [SLOT_W-1:0]          slot_q;
  logic signed [ACC_W-1:0]    wsum_q, psum_q;
  logic [DEN_W-1:0]           wtot_q;
  logic [SAMPLE_W-1:0]        rd_data;
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [CNT_W+SAMPLE_W:0] prod;

  // Sequencer outputs.
  logic rd_issue;
  logic div_start;
  logic div_sel_p;
  logic out_load;

  // Shared divider.
  logic [ACC_W-1:0]    wabs, pabs, div_num;
  logic [DEN_W-1:0]    div_den;
  logic [QUO_W-1:0]    quo;
  div_stat_t           div_stat;
  logic [SAMPLE_W-1:0] w_res, p_res;
  logic signed [SAMPLE_W-1:0] wq_q;

  // Output register.
  out_item_t out_q;
  logic      out_valid_q;
  logic [SER_W+1:0] ser_out_ext;

  // ---------------------------------------------------------------------------
  // Input decode: widen the series field so any SERIES_COUNT compares cleanly.
  // ---------------------------------------------------------------------------
  assign in_ser_ext = {{SER_W{1'b0}}, in_item_i.series};
  assign in_idx     = in_ser_ext[SER_W-1:0];
  assign in_range   = in_ser_ext < (SER_W + 2)'(SERIES_COUNT);
  assign in_acc     = in_valid_i & in_ready_o;

  // Advance the ring pointer; the new sample lands at the slot after today's.
  assign head_cur = head_q[in_idx];
  assign fill_cur = fill_q[in_idx];
  assign head_new = (head_cur == SLOT_W'(WINDOW - 1)) ? '0 : head_cur + SLOT_W'(1);
  assign fill_new = (fill_cur == CNT_W'(WINDOW)) ? fill_cur : fill_cur + CNT_W'(1);

  // ---------------------------------------------------------------------------
  // History store: one row of 2**SLOT_W entries per series.
  // ---------------------------------------------------------------------------
  tdta_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (in_acc & in_range),
    .waddr_i ({in_idx, head_new}),
    .wdata_i (in_item_i.sample),
    .re_i    (rd_issue),
    .raddr_i ({ser_q, slot_q}),
    .rdata_o (rd_data)
  );

  // One weight-times-sample product per cycle, registered into the sums.
  assign rd_sample = $signed(rd_data);
  assign prod      = $signed({1'b0, w_q}) * rd_sample;

  // ---------------------------------------------------------------------------
  // Divider operand select: weighted sum first, then the plain sum.
  // ---------------------------------------------------------------------------
  assign wabs    = wsum_q[ACC_W-1] ? $unsigned(-wsum_q) : $unsigned(wsum_q);
  assign pabs    = psum_q[ACC_W-1] ? $unsigned(-psum_q) : $unsigned(psum_q);
  assign div_num = div_sel_p ? pabs : wabs;
  assign div_den = div_sel_p ? DEN_W'(n_q) : wtot_q;

  tdta_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  // Restore the sign: truncation toward zero is division of magnitudes.
  assign w_res = wsum_q[ACC_W-1] ? (~quo + QUO_W'(1)) : quo;
  assign p_res = psum_q[ACC_W-1] ? (~quo + QUO_W'(1)) : quo;

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_range) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (rd_cnt_q == n_q && !pend_q) begin
          state_d = ST_WSTART;
        end
      end
      ST_WSTART: state_d = ST_WWAIT;
      ST_WWAIT: begin
        if (div_stat.done) begin
          state_d = ST_PSTART;
        end
      end
      ST_PSTART: state_d = ST_PWAIT;
      ST_PWAIT: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    rd_issue   = 1'b0;
    div_start  = 1'b0;
    div_sel_p  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SUM:    rd_issue   = (rd_cnt_q != n_q);
      ST_WSTART: div_start  = 1'b1;
      ST_WWAIT:  div_sel_p  = 1'b0;
      ST_PSTART: begin
        div_start = 1'b1;
        div_sel_p = 1'b1;
      end
      ST_PWAIT:  div_sel_p  = 1'b1;
      ST_OUT:    out_load   = !out_valid_q || out_ready_i;
      default:   in_ready_o = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      rd_cnt_q    <= '0;
      n_q         <= '0;
      ser_q       <= '0;
      for (int i = 0; i < SERIES_COUNT; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
      pend_q      <= rd_issue;
      if (in_acc && in_range) begin
        head_q[in_idx] <= head_new;
        fill_q[in_idx] <= fill_new;
        n_q            <= fill_new;
        ser_q          <= in_idx;
        rd_cnt_q       <= '0;
      end else if (rd_issue) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers: walk the ring from today backward, then divide.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      slot_q <= head_new;
      wsum_q <= '0;
      psum_q <= '0;
      wtot_q <= '0;
    end else begin
      if (rd_issue) begin
        slot_q <= (slot_q == '0) ? SLOT_W'(WINDOW - 1) : slot_q - SLOT_W'(1);
        w_q    <= CNT_W'(WINDOW) - rd_cnt_q;
      end
      if (pend_q) begin
        wsum_q <= wsum_q + ACC_W'(prod);
        psum_q <= psum_q + ACC_W'(rd_sample);
        wtot_q <= wtot_q + DEN_W'(w_q);
      end
    end
    if (state_q == ST_WWAIT && div_stat.done) begin
      wq_q <= $signed(w_res);
    end
    if (out_load) begin
      out_q.series_out    <= ser_out_ext[SERIES_W-1:0];
      out_q.weighted_mean <= wq_q;
      out_q.plain_mean    <= $signed(p_res);
    end
  end

  assign ser_out_ext = {2'b00, ser_q};

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/tdta_chk.sv
// Port-level checker for the temperature averager, bound to the top level.
`include "ten_day_temperature_averager_core_macros.svh"

module tdta_chk
  import tdta_pkg::*;
#(
  parameter int unsigned SERIES_COUNT = 4
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Hold a stalled result and its payload.
  `TDTA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "result dropped or changed while stalled")

  // Drop ready after taking an item for a live series.
  `TDTA_ASSERT(a_busy_after_take, in_valid_i && in_ready_o && (in_item_i.series < SERIES_COUNT) |=> !in_ready_o, "ready stayed high after a live item")

  // A new result only comes out of a busy period.
  `TDTA_ASSERT(a_result_after_busy, $rose(out_valid_o) |-> $past(!in_ready_o), "result appeared without work")

  // Tag every result with a live series.
  `TDTA_ASSERT_ALWAYS(a_series_live, !out_valid_o || (out_item_o.series_out < SERIES_COUNT), "result for a series that does not exist")

endmodule

bind ten_day_temperature_averager_core tdta_chk #(
  .SERIES_COUNT (SERIES_COUNT)
) u_tdta_chk (.*);

// File: tb/tb.sv
// Self-checking testbench of the ten-day temperature averager core.
`timescale 1ns / 100ps

module tb;
  import tdta_pkg::*;

  localparam int unsigned WINDOW       = 10;
  localparam int unsigned SERIES_COUNT = 4;
  localparam int unsigned RANDOM_ITEMS = 1300;
  // The slowest honest stretch without a handshake is one item's latency
  // with a full window plus a random stall or gap.
  // Take that many times over.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;

  // Track the sample windows of every series and keep the averages
  // still owed by the block, oldest first.
  class TempWindowBoard;
    logic signed [SAMPLE_W-1:0] days[SERIES_COUNT][WINDOW];
    int unsigned                held[SERIES_COUNT];
    out_item_t                  owed_q[$];
    int unsigned                errors;

    function new();
      errors = 0;
      foreach (held[s]) held[s] = 0;
    endfunction

    // Shift an accepted sample in and work out the two averages it yields.
    function void note_sample(in_item_t it);
      int unsigned s;
      int unsigned k;
      longint      wsum;
      longint      psum;
      longint      wtot;
      out_item_t   avg;
      s = it.series;
      if (s >= SERIES_COUNT) return;
      for (k = WINDOW - 1; k > 0; k--) days[s][k] = days[s][k-1];
      days[s][0] = it.sample;
      if (held[s] < WINDOW) held[s]++;
      wsum = 0;
      psum = 0;
      wtot = 0;
      for (k = 0; k < held[s]; k++) begin
        wsum += longint'(WINDOW - k) * longint'(days[s][k]);
        psum += longint'(days[s][k]);
        wtot += longint'(WINDOW - k);
      end
      avg.series_out    = it.series;
      avg.weighted_mean = SAMPLE_W'(wsum / wtot);
      avg.plain_mean    = SAMPLE_W'(psum / longint'(held[s]));
      owed_q.push_back(avg);
    endfunction

    // Compare a delivered result with the oldest owed one.
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none owed: series %0d wmean %0d pmean %0d",
                 $time, got.series_out, got.weighted_mean, got.plain_mean);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.series_out !== want.series_out) begin
        $display("%0t: series_out expected %0d actual %0d",
                 $time, want.series_out, got.series_out);
        errors++;
      end
      if (got.weighted_mean !== want.weighted_mean) begin
        $display("%0t: weighted_mean expected %0d actual %0d",
                 $time, want.weighted_mean, got.weighted_mean);
        errors++;
      end
      if (got.plain_mean !== want.plain_mean) begin
        $display("%0t: plain_mean expected %0d actual %0d",
                 $time, want.plain_mean, got.plain_mean);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  TempWindowBoard board;
  bit             calm;
  int unsigned    quiet_cycles;

  ten_day_temperature_averager_core #(
    .WINDOW      (WINDOW),
    .SERIES_COUNT(SERIES_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Present one item at a falling edge and hold it until the block takes it.
  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(it);
  endtask

  // Drop valid for a random burst, unless the run is in a calm stretch.
  task automatic maybe_pause_sender();
    int unsigned gap;
    if (calm || $urandom_range(0, 3) != 0) return;
    gap = $urandom_range(1, 13);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (gap - 1) @(negedge clk_i);
  endtask

  // Hold off new items until every owed result has come out.
  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Mix full-range noise, edge values and plausible daily temperatures.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh7fff;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          default: v = 16'shffff;
        endcase
      end
      1, 2, 3, 4: v = SAMPLE_W'($urandom());
      // -40 .. +50 degrees in Q8.8
      default: v = SAMPLE_W'(int'($urandom_range(0, 90 * 256)) - 40 * 256);
    endcase
    return v;
  endfunction

  // Stall the result side in random bursts; keep it open in calm stretches.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  // Check every result at the edge where it is handed over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_item_o);
  end

  // End the run if the handshakes go quiet for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results owed",
               $time, QUIET_LIMIT, board.pending());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t it;
    int       i;
    board        = new();
    calm         = 1'b0;
    quiet_cycles = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_ready_i  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Fill series 0 with the top value past a full window
    // so the oldest day drops out while the weighted sum is at its peak.
    for (i = 0; i < WINDOW + 1; i++) begin
      it.series = 2'd0;
      it.sample = 16'sh7fff;
      send_item(it);
    end
    // Start series 1 at the bottom value: short windows, negative sums.
    for (i = 0; i < 3; i++) begin
      it.series = 2'd1;
      it.sample = 16'sh8000;
      send_item(it);
    end
    // Small values on series 2 probe truncation toward zero on both signs.
    it.series = 2'd2;
    it.sample = 16'sh0000;
    send_item(it);
    it.sample = 16'shffff;
    send_item(it);
    it.sample = 16'sh0001;
    send_item(it);
    it.sample = 16'sh0100;
    send_item(it);
    // Alternate the extremes on series 3.
    for (i = 0; i < 4; i++) begin
      it.series = 2'd3;
      it.sample = i[0] ? 16'sh8000 : 16'sh7fff;
      send_item(it);
    end
    // Flip series 0 to the bottom value under a full window.
    it.series = 2'd0;
    it.sample = 16'sh8000;
    send_item(it);

    // Let the directed items drain before the random part.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    // Random part: calm stretch in the middle and at the tail.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 500 && i < 600) || (i >= RANDOM_ITEMS - 150);
      if (i == 400 || i == 900) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end else begin
        maybe_pause_sender();
      end
      it.series = SERIES_W'($urandom_range(0, SERIES_COUNT - 1));
      it.sample = pick_sample();
      send_item(it);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray result.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: ten_day_temperature_averager_core.f
+incdir+hdl
hdl/tdta_pkg.sv
hdl/tdta_ram.sv
hdl/tdta_div.sv
hdl/ten_day_temperature_averager_core.sv
hdl/tdta_chk.sv
tb/tb.sv
